@@ sv/aslrb_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// aslrb_pkg
// shared types and constants of the audio sample limiter ring buffer
// ----------------------------------------------------------------------------
package aslrb_pkg;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_MAX_AMP   = 2'd0,
    CFG_VOL_GAIN  = 2'd1,
    CFG_LIMIT_THR = 2'd2
  } cfg_idx_t;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;
  localparam int SAMPLE_IN_W  = 20;
  localparam int SAMPLE_OUT_W = 16;

  localparam logic [14:0] MAX_AMP_RST   = 15'd32767;
  localparam logic [16:0] VOL_GAIN_RST  = 17'd32768;
  localparam logic [14:0] LIMIT_THR_RST = 15'd31130;

  // q16 unity gain and the +-1.0 clamp bounds of a q3.16 input
  localparam logic [16:0]        GAIN_UNITY = 17'h10000;
  localparam logic signed [19:0] X_POS_ONE  = 20'sd65536;
  localparam logic signed [19:0] X_NEG_ONE  = -20'sd65536;

  // rounding bias for truncation toward zero after a 16-bit right shift
  localparam logic signed [33:0] TRUNC_BIAS = 34'sd65535;

  localparam logic signed [17:0] SAT_POS = 18'sd32767;
  localparam logic signed [17:0] SAT_NEG = -18'sd32768;

  typedef struct packed {
    logic [14:0] full_scale;
    logic [16:0] volume_gain;
    logic [14:0] limit_threshold;
  } cfg_t;

  // request passed from the front to the back
  typedef struct packed {
    logic                            is_read;
    logic                            batch_end;
    logic signed [SAMPLE_OUT_W-1:0]  sample;
  } req_t;

  // result transaction
  typedef struct packed {
    logic signed [SAMPLE_OUT_W-1:0]  sample_out;
    logic                            last;
    logic                            empty_res;
  } res_t;

endpackage
`default_nettype wire

@@ sv/aslrb_fifo.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// aslrb_fifo
// small register fifo, depth a power of two
// ----------------------------------------------------------------------------
module aslrb_fifo #(
  parameter int DEPTH = 2,
  parameter int WIDTH = 8
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       push,
  input  wire logic [WIDTH-1:0]           push_data,
  input  wire logic                       pop,
  output logic      [WIDTH-1:0]           pop_data,
  output logic                            not_empty,
  output logic                            full,
  output logic      [$clog2(DEPTH):0]     count
);

  localparam int PTR_W = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W:0]   count_r;
  logic [PTR_W:0]   count_nxt;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  assign pop_data  = mem_r[rd_ptr_r];
  assign not_empty = (count_r != '0);
  assign full      = (count_r == (PTR_W+1)'(DEPTH));
  assign count     = count_r;

endmodule
`default_nettype wire

@@ sv/aslrb_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// aslrb_front
// takes input transactions, conditions write samples, queues requests
// ----------------------------------------------------------------------------
module aslrb_front
  import aslrb_pkg::*;
(
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire cfg_t                           cfg,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           in_is_read,
  input  wire logic signed [SAMPLE_IN_W-1:0]  in_sample,
  input  wire logic                           in_batch_end,
  output logic                                q_push,
  output req_t                                q_item,
  input  wire logic                           q_full
);

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_MUL1 = 4'b0010,
    F_MUL2 = 4'b0100,
    F_PUSH = 4'b1000
  } front_state_t;

  front_state_t state_r, state_nxt;

  logic signed [SAMPLE_IN_W-1:0]  x_r;
  logic                           is_read_r;
  logic                           batch_end_r;
  logic signed [15:0]             s1_r;
  logic signed [15:0]             s2_r;

  logic signed [19:0] x_clamp;
  logic signed [17:0] x_c;
  logic signed [33:0] p1, p1_b;
  logic signed [33:0] p2, p2_b;
  logic signed [17:0] q2;
  logic signed [15:0] s2_sat;
  logic signed [15:0] thr, thr_neg, s_lim;

  // clamp to +-1.0 then scale to full scale
  always_comb begin
    if (x_r > X_POS_ONE) begin
      x_clamp = X_POS_ONE;
    end else if (x_r < X_NEG_ONE) begin
      x_clamp = X_NEG_ONE;
    end else begin
      x_clamp = x_r;
    end
    x_c  = x_clamp[17:0];
    p1   = x_c * $signed({1'b0, cfg.full_scale});
    p1_b = p1 + (p1[33] ? TRUNC_BIAS : 34'sd0);
  end

  // volume gain with saturation
  always_comb begin
    p2   = s1_r * $signed({1'b0, cfg.volume_gain});
    p2_b = p2 + (p2[33] ? TRUNC_BIAS : 34'sd0);
    q2   = p2_b[33:16];
    if (cfg.volume_gain == GAIN_UNITY) begin
      s2_sat = s1_r;
    end else if (q2 > SAT_POS) begin
      s2_sat = SAT_POS[15:0];
    end else if (q2 < SAT_NEG) begin
      s2_sat = SAT_NEG[15:0];
    end else begin
      s2_sat = q2[15:0];
    end
  end

  // hard limiter
  always_comb begin
    thr     = $signed({1'b0, cfg.limit_threshold});
    thr_neg = -thr;
    if (s2_r > thr) begin
      s_lim = thr;
    end else if (s2_r < thr_neg) begin
      s_lim = thr_neg;
    end else begin
      s_lim = s2_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE: begin
        if (in_valid) state_nxt = in_is_read ? F_PUSH : F_MUL1;
      end
      F_MUL1: state_nxt = F_MUL2;
      F_MUL2: state_nxt = F_PUSH;
      F_PUSH: begin
        if (!q_full) state_nxt = F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == F_IDLE && in_valid) begin
      x_r         <= in_sample;
      is_read_r   <= in_is_read;
      batch_end_r <= in_batch_end;
    end
    if (state_r == F_MUL1) s1_r <= p1_b[31:16];
    if (state_r == F_MUL2) s2_r <= s2_sat;
  end

  assign in_ready         = (state_r == F_IDLE);
  assign q_push           = (state_r == F_PUSH) && !q_full;
  assign q_item.is_read   = is_read_r;
  assign q_item.batch_end = batch_end_r;
  assign q_item.sample    = s_lim;

endmodule
`default_nettype wire

@@ sv/aslrb_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// aslrb_back
// ring memory, pointers, overrun drop and read burst sequencing
// ----------------------------------------------------------------------------
module aslrb_back
  import aslrb_pkg::*;
#(
  parameter int RING_DEPTH = 4096,
  parameter int BURST      = 64,
  parameter int OUT_DEPTH  = 4
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         q_valid,
  input  wire req_t                         q_item,
  output logic                              q_pop,
  output logic                              res_push,
  output res_t                              res_item,
  input  wire logic [$clog2(OUT_DEPTH):0]   out_count
);

  localparam int PTR_W = $clog2(RING_DEPTH);
  localparam int REM_W = $clog2(BURST + 1);
  localparam int CNT_W = $clog2(OUT_DEPTH) + 1;
  localparam int OCC_HI  = RING_DEPTH * 3 / 4;
  localparam int QUARTER = RING_DEPTH / 4;

  typedef enum logic [3:0] {
    B_IDLE  = 4'b0001,
    B_CHECK = 4'b0010,
    B_BURST = 4'b0100,
    B_EMPTY = 4'b1000
  } back_state_t;

  back_state_t state_r, state_nxt;

  logic signed [15:0] ring_r [RING_DEPTH];
  logic [PTR_W-1:0]   wp_r;
  logic [PTR_W-1:0]   rp_r;
  logic [REM_W-1:0]   rem_r;
  logic               rd_valid_r;
  logic               rd_last_r;
  logic signed [15:0] rd_data_r;

  logic [PTR_W-1:0] wp_inc, rp_inc;
  logic [PTR_W:0]   occ_full;
  logic [PTR_W:0]   jump_sum, jump;
  logic [CNT_W:0]   credit;
  logic             room;
  logic             issue;
  logic             empty_push;
  logic             take_write, take_read;

  assign wp_inc = (wp_r == PTR_W'(RING_DEPTH - 1)) ? '0 : wp_r + 1'b1;
  assign rp_inc = (rp_r == PTR_W'(RING_DEPTH - 1)) ? '0 : rp_r + 1'b1;

  // occupancy as (wp - rp) mod depth
  assign occ_full = {1'b0, wp_r} - {1'b0, rp_r}
                  + ((wp_r < rp_r) ? (PTR_W+1)'(RING_DEPTH) : '0);

  assign jump_sum = {1'b0, wp_r} + (PTR_W+1)'(QUARTER);
  assign jump     = (jump_sum >= (PTR_W+1)'(RING_DEPTH))
                  ? jump_sum - (PTR_W+1)'(RING_DEPTH) : jump_sum;

  // output fifo slots taken, counting the read in flight
  assign credit = {1'b0, out_count} + (CNT_W+1)'(rd_valid_r);
  assign room   = credit < (CNT_W+1)'(OUT_DEPTH);

  assign q_pop      = (state_r == B_IDLE) && q_valid;
  assign take_write = q_pop && !q_item.is_read;
  assign take_read  = q_pop && q_item.is_read;
  assign issue      = (state_r == B_BURST) && room;
  assign empty_push = (state_r == B_EMPTY) && room && !rd_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: begin
        if (take_write && q_item.batch_end) begin
          state_nxt = B_CHECK;
        end else if (take_read) begin
          state_nxt = (occ_full == '0) ? B_EMPTY : B_BURST;
        end
      end
      B_CHECK: state_nxt = B_IDLE;
      B_BURST: begin
        if (issue && rem_r == REM_W'(1)) state_nxt = B_IDLE;
      end
      B_EMPTY: begin
        if (empty_push) state_nxt = B_IDLE;
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= B_IDLE;
      wp_r       <= '0;
      rp_r       <= '0;
      rem_r      <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      rd_valid_r <= issue;
      if (take_write) wp_r <= wp_inc;
      if (state_r == B_CHECK && occ_full > (PTR_W+1)'(OCC_HI)) begin
        rp_r <= jump[PTR_W-1:0];
      end else if (issue) begin
        rp_r <= rp_inc;
      end
      if (take_read) begin
        rem_r <= (occ_full < (PTR_W+1)'(BURST)) ? REM_W'(occ_full) : REM_W'(BURST);
      end else if (issue) begin
        rem_r <= rem_r - 1'b1;
      end
    end
  end

  // ring memory, one write port and one registered read port
  always_ff @(posedge clk) begin
    if (take_write) ring_r[wp_r] <= q_item.sample;
    if (issue) begin
      rd_data_r <= ring_r[rp_r];
      rd_last_r <= (rem_r == REM_W'(1));
    end
  end

  assign res_push = rd_valid_r || empty_push;

  always_comb begin
    if (rd_valid_r) begin
      res_item.sample_out = rd_data_r;
      res_item.last       = rd_last_r;
      res_item.empty_res  = 1'b0;
    end else begin
      res_item.sample_out = '0;
      res_item.last       = 1'b1;
      res_item.empty_res  = 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> (out_count < CNT_W'(OUT_DEPTH)))
    else $error("result pushed into a full output fifo");

  a_burst_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_BURST) |-> (rem_r != '0))
    else $error("burst state with nothing left to read");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (issue && rem_r == REM_W'(1)) |=> (state_r == B_IDLE && rd_last_r))
    else $error("final burst read did not close the burst");

  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (rp_r <= PTR_W'(RING_DEPTH - 1)) && (wp_r <= PTR_W'(RING_DEPTH - 1)))
    else $error("ring pointer out of range");
`endif

endmodule
`default_nettype wire

@@ sv/audio_sample_limiter_ring_buffer.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// audio_sample_limiter_ring_buffer
// sample conditioning limiter feeding a ring buffer that drops old data
// ----------------------------------------------------------------------------
// usage
//   in_*  : one transaction per request; tuser 0 writes the q3.16 sample in
//           tdata, tuser 1 asks for a read burst; tlast marks batch end
//   out_* : one transaction per stored sample, tlast on the burst's final one,
//           tuser set on the single result that reports an empty ring
//   cfg_* : plain register writes, only while the block is idle
// timing
//   a write steps through the front (capture, two multiplies each behind a
//   register, limit and queue), and the front takes no new request meanwhile
//   a read request passes from the front through the request queue to the back;
//   the back reads the ring into a register and offers the results, one per cycle
//   from the single ring read port while out_tready stays high
//   a 2-entry request queue lets the front take new requests while the back
//   drains a burst; a 4-entry output fifo absorbs receiver stalls
// reset
//   pointers and control clear at once, no clearing pass; ring contents stay
//   undefined until written, registers return to their defaults
// ----------------------------------------------------------------------------
module audio_sample_limiter_ring_buffer
  import aslrb_pkg::*;
#(
  parameter int RING_DEPTH = 4096,
  parameter int BURST      = 64
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // in_tdata: sample_in [19:0], zero pad [23:20]
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [23:0]            in_tdata,
  input  wire logic                   in_tlast,
  // in_tuser: req_type [0]
  input  wire logic                   in_tuser,
  // out_tdata: sample_out [15:0]
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [15:0]                 out_tdata,
  output logic                        out_tlast,
  // out_tuser: empty_res [0]
  output logic                        out_tuser,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int Q_DEPTH   = 2;
  localparam int OUT_DEPTH = 4;

  cfg_t cfg_r;

  logic  q_push, q_pop, q_full, q_not_empty;
  req_t  q_in, q_out;
  logic [$clog2(Q_DEPTH):0] q_count;

  logic  res_push, out_pop, out_full;
  res_t  res_in, res_out;
  logic [$clog2(OUT_DEPTH):0] out_count;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.full_scale      <= MAX_AMP_RST;
      cfg_r.volume_gain     <= VOL_GAIN_RST;
      cfg_r.limit_threshold <= LIMIT_THR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_AMP:   cfg_r.full_scale      <= cfg_wdata[14:0];
        CFG_VOL_GAIN:  cfg_r.volume_gain     <= cfg_wdata;
        CFG_LIMIT_THR: cfg_r.limit_threshold <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  // front: accepts and conditions requests
  aslrb_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .in_is_read   (in_tuser),
    .in_sample    ($signed(in_tdata[SAMPLE_IN_W-1:0])),
    .in_batch_end (in_tlast),
    .q_push       (q_push),
    .q_item       (q_in),
    .q_full       (q_full)
  );

  // request queue between front and back
  aslrb_fifo #(
    .DEPTH (Q_DEPTH),
    .WIDTH ($bits(req_t))
  ) u_req_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .not_empty (q_not_empty),
    .full      (q_full),
    .count     (q_count)
  );

  // back: ring, pointers, burst reads
  aslrb_back #(
    .RING_DEPTH (RING_DEPTH),
    .BURST      (BURST),
    .OUT_DEPTH  (OUT_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_not_empty && (q_count != '0)),
    .q_item    (q_out),
    .q_pop     (q_pop),
    .res_push  (res_push),
    .res_item  (res_in),
    .out_count (out_count)
  );

  // output fifo parts the back from a stalling receiver
  aslrb_fifo #(
    .DEPTH (OUT_DEPTH),
    .WIDTH ($bits(res_t))
  ) u_out_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res_in),
    .pop       (out_pop),
    .pop_data  (res_out),
    .not_empty (out_tvalid),
    .full      (out_full),
    .count     (out_count)
  );

  assign out_pop   = out_tvalid && out_tready;
  assign out_tdata = res_out.sample_out;
  assign out_tlast = res_out.last;
  assign out_tuser = res_out.empty_res;

`ifndef SYNTHESIS
  a_out_full_push: assert property (@(posedge clk) disable iff (!rst_n)
    (out_full && !out_pop) |-> !res_push)
    else $error("output fifo overrun");
`endif

endmodule
`default_nettype wire

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the audio sample limiter ring buffer: a local
// model of the conditioning arithmetic, the ring and its pointers predicts
// every result transaction, which is compared field by field as it leaves
// ----------------------------------------------------------------------------
module tb_top;
  import aslrb_pkg::*;

  localparam int DEPTH         = 4096;
  localparam int BURST_LEN     = 64;
  localparam int LIMIT         = 1000000;
  // a write passes through the front and may sit in the request queue
  localparam int SETTLE_CYCLES = 24;
  localparam int DRAIN_LIMIT   = 50000;
  localparam longint Q_ONE     = 65536;

  // request kinds carried on in_tuser
  localparam logic RT_WRITE = 1'b0;
  localparam logic RT_READ  = 1'b1;
  // register index with no register behind it
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [23:0]           in_tdata   = '0;
  logic                  in_tlast   = 1'b0;
  logic                  in_tuser   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [15:0]           out_tdata;
  logic                  out_tlast;
  logic                  out_tuser;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

  // model state: ring contents, pointers and the three registers
  logic [15:0] ring_mem [DEPTH];
  int          rd_ptr   = 0;
  int          wr_ptr   = 0;
  logic [14:0] amp_reg  = MAX_AMP_RST;
  logic [16:0] gain_reg = VOL_GAIN_RST;
  logic [14:0] thr_reg  = LIMIT_THR_RST;

  // results still owed by the block, oldest first
  res_t        burst_q [$];
  res_t        want_res;

  int          fail_cnt      = 0;
  int          cycle_cnt     = 0;
  int          src_idle_pct  = 0;
  int          snk_stall_pct = 0;

  always #5 clk = ~clk;

  audio_sample_limiter_ring_buffer #(
    .RING_DEPTH (DEPTH),
    .BURST      (BURST_LEN)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // model
  // --------------------------------------------------------------------------

  // occupied entries; equal pointers read as empty even when the ring is full
  function automatic int ring_fill();
    return (wr_ptr + DEPTH - rd_ptr) % DEPTH;
  endfunction

  // clamp to +-1.0, scale to full scale, apply volume, saturate, then clip
  function automatic logic [15:0] shape_level(logic signed [19:0] x_in);
    longint x;
    longint s;
    longint t;
    x = x_in;
    t = longint'(thr_reg);
    if (x > Q_ONE) x = Q_ONE;
    if (x < -Q_ONE) x = -Q_ONE;
    // longint division truncates toward zero
    s = (x * longint'(amp_reg)) / Q_ONE;
    // unity gain bypasses the volume stage altogether
    if (gain_reg != GAIN_UNITY) begin
      s = (s * longint'(gain_reg)) / Q_ONE;
      if (s > 32767) s = 32767;
      if (s < -32768) s = -32768;
    end
    if (s > t) s = t;
    else if (s < -t) s = -t;
    return s[15:0];
  endfunction

  // advance the model by one accepted request transaction
  task automatic apply_request(input logic rd, input logic signed [19:0] smp,
                               input logic be);
    int   avail;
    int   n;
    int   i;
    res_t r;
    if (rd == RT_WRITE) begin
      ring_mem[wr_ptr] = shape_level(smp);
      wr_ptr = (wr_ptr + 1) % DEPTH;
      // overrun: at batch end past three quarters full, drop the oldest so three quarters remain
      if (be && ring_fill() > DEPTH * 3 / 4) rd_ptr = (wr_ptr + DEPTH / 4) % DEPTH;
    end else begin
      avail = ring_fill();
      if (avail == 0) begin
        r.sample_out = '0;
        r.last       = 1'b1;
        r.empty_res  = 1'b1;
        burst_q = {burst_q, r};
      end else begin
        n = (avail < BURST_LEN) ? avail : BURST_LEN;
        for (i = 0; i < n; i++) begin
          r.sample_out = ring_mem[rd_ptr];
          r.last       = (i == n - 1);
          r.empty_res  = 1'b0;
          burst_q = {burst_q, r};
          rd_ptr = (rd_ptr + 1) % DEPTH;
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // drivers
  // --------------------------------------------------------------------------

  function automatic int pick_gap(int pct);
    int g;
    g = 0;
    while (g < 40 && $urandom_range(99) < pct) g++;
    return g;
  endfunction

  task automatic set_idling(input int src_pct, input int snk_pct);
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
  endtask

  // one request transaction; called and returns on a rising edge. valid is
  // only dropped ahead of an idle gap, so it never falls and rises in a step
  task automatic send_req(input logic rd, input logic [19:0] smp, input logic be);
    int gap;
    gap = pick_gap(src_idle_pct);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0000, smp};
    in_tlast  <= be;
    in_tuser  <= rd;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    apply_request(rd, $signed(smp), be);
  endtask

  // stop sending, let every owed result arrive and the front go quiet
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (burst_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_MAX_AMP:   amp_reg  = val[14:0];
      CFG_VOL_GAIN:  gain_reg = val[16:0];
      CFG_LIMIT_THR: thr_reg  = val[14:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_regs(input int amp, input int gain, input int thr);
    write_reg(CFG_MAX_AMP, CFG_DATA_W'(amp));
    write_reg(CFG_VOL_GAIN, CFG_DATA_W'(gain));
    write_reg(CFG_LIMIT_THR, CFG_DATA_W'(thr));
  endtask

  // the +-1.0 span and small values near zero, with clamp edges and wide noise mixed in
  function automatic logic [19:0] rand_sample();
    int rims [6] = '{65536, -65536, 65537, -65537, 524287, -524288};
    case ($urandom_range(3))
      0:       return 20'($urandom);
      1:       return 20'(int'($urandom_range(131072)) - 65536);
      2:       return 20'(rims[$urandom_range(5)]);
      default: return 20'(int'($urandom_range(512)) - 256);
    endcase
  endfunction

  task automatic drain_ring();
    while (ring_fill() > 0) send_req(RT_READ, rand_sample(), $urandom_range(1));
  endtask

  // --------------------------------------------------------------------------
  // result checking and receiver stalls
  // --------------------------------------------------------------------------

  task automatic flag_mismatch(input res_t want);
    fail_cnt++;
    if (fail_cnt <= 10)
      $display("mismatch: exp sample %0d last %0b empty %0b, got %0d last %0b empty %0b",
               $signed(want.sample_out), want.last, want.empty_res,
               $signed(out_tdata), out_tlast, out_tuser);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (burst_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10)
          $display("unexpected result transaction: sample %0d last %0b empty %0b",
                   $signed(out_tdata), out_tlast, out_tuser);
      end else begin
        want_res = burst_q.pop_front();
        if (out_tdata !== want_res.sample_out || out_tlast !== want_res.last ||
            out_tuser !== want_res.empty_res)
          flag_mismatch(want_res);
      end
    end
    out_tready <= ($urandom_range(99) >= snk_stall_pct);
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // freshly reset ring reads as empty; batch end on a read does nothing
  task automatic test_empty_read();
    set_idling(0, 0);
    send_req(RT_READ, rand_sample(), 1'b0);
    send_req(RT_READ, rand_sample(), 1'b1);
  endtask

  // clamp and truncation corners under the default registers
  task automatic test_sample_extremes();
    int vals [14] = '{0, 1, -1, 3, -3, 32768, -32768, 65535, 65536, -65536,
                      65537, -65537, 524287, -524288};
    int i;
    set_idling(65, 0);
    for (i = 0; i < 14; i++) send_req(RT_WRITE, 20'(vals[i]), (i == 6 || i == 13));
    send_req(RT_READ, '0, 1'b0);
    // burst took everything, so the next read is empty
    send_req(RT_READ, '1, 1'b1);
  endtask

  // register extremes: unity bypass, oversized gain, zero gain, zero scale,
  // zero and minimal thresholds; the spare index must change nothing
  task automatic test_register_settings();
    int amps  [7] = '{32767, 32767,  32767, 0,     32767, 1,     12345};
    int gains [7] = '{65536, 131071, 0,     32768, 65535, 65537, 98304};
    int thrs  [7] = '{32767, 32767,  31130, 31130, 0,     1,     20000};
    int p;
    for (p = 0; p < 7; p++) begin
      wait_idle();
      case (p % 4)
        0:       set_idling(0, 0);
        1:       set_idling(65, 0);
        2:       set_idling(0, 65);
        default: set_idling(30, 30);
      endcase
      load_regs(amps[p], gains[p], thrs[p]);
      write_reg(CFG_IDX_SPARE, CFG_DATA_W'($urandom));
      send_req(RT_WRITE, 20'sd65536, 1'b0);
      send_req(RT_WRITE, -20'sd65536, 1'b0);
      send_req(RT_WRITE, 20'h7FFFF, 1'b0);
      send_req(RT_WRITE, 20'h80000, 1'b0);
      send_req(RT_WRITE, rand_sample(), 1'b0);
      send_req(RT_WRITE, rand_sample(), 1'b1);
      send_req(RT_READ, rand_sample(), $urandom_range(1));
    end
  endtask

  // batches of writes closed by batch end, read bursts, stray reads, with a
  // fresh register setting and idling pattern for each quarter of the run
  task automatic test_random_traffic();
    int mode;
    int sent;
    int len;
    int k;
    int pick;
    int gain;
    for (mode = 0; mode < 4; mode++) begin
      wait_idle();
      case (mode)
        0:       set_idling(0, 0);
        1:       set_idling(65, 0);
        2:       set_idling(0, 65);
        default: set_idling(30, 30);
      endcase
      case ($urandom_range(2))
        0:       gain = $urandom_range(65536);
        1:       gain = 65536;
        default: gain = $urandom_range(131071, 65537);
      endcase
      load_regs($urandom_range(32767), gain, $urandom_range(32767));
      sent = 0;
      while (sent < 55) begin
        pick = $urandom_range(99);
        if (pick < 70) begin
          len = $urandom_range(24, 1);
          for (k = 0; k < len; k++) begin
            send_req(RT_WRITE, rand_sample(), (k == len - 1) || ($urandom_range(15) == 0));
            sent++;
          end
        end else if (pick < 92) begin
          len = $urandom_range(3, 1);
          for (k = 0; k < len; k++) begin
            send_req(RT_READ, rand_sample(), $urandom_range(1));
            sent++;
          end
        end else begin
          // run the ring dry and read once more for an empty result
          drain_ring();
          send_req(RT_READ, rand_sample(), $urandom_range(1));
          sent++;
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // sequence
  // --------------------------------------------------------------------------

  initial begin
    int w;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_read();
    test_sample_extremes();
    test_register_settings();
    test_random_traffic();
    in_tvalid <= 1'b0;
    for (w = 0; w < DRAIN_LIMIT && burst_q.size() != 0; w++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (burst_q.size() != 0) begin
      $display("%0d expected result transactions never arrived", burst_q.size());
      fail_cnt += burst_q.size();
    end
    if (fail_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
